// ----- rtl/zwsd_pkg.sv -----
// Shared types and constants for the zero-width text decoder.
// Depends on nothing; every other file of the block imports it.
package zwsd_pkg;

	localparam int DIGEST_BYTES  = 16;
	localparam int MARKER_WINDOW = 9;
	localparam int DCNT_W        = $clog2(DIGEST_BYTES + 1);
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] BYTE_E2 = 8'he2;
	localparam logic [7:0] BYTE_80 = 8'h80;
	localparam logic [7:0] BYTE_8B = 8'h8b;
	localparam logic [7:0] BYTE_8C = 8'h8c;
	localparam logic [7:0] BYTE_8D = 8'h8d;
	localparam logic [7:0] BYTE_81 = 8'h81;
	localparam logic [7:0] BYTE_A0 = 8'ha0;
	localparam logic [7:0] BYTE_CD = 8'hcd;
	localparam logic [7:0] BYTE_8F = 8'h8f;

	localparam logic ERR_NO_MARKER = 1'b0;
	localparam logic ERR_BAD_LEAD  = 1'b1;

	typedef enum logic [1:0] {
		MODE_HUNT,
		MODE_DECODE,
		MODE_ERR_MARKER,
		MODE_ERR_LEAD
	} mode_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD,
		KIND_DIGEST,
		KIND_END,
		KIND_ERROR
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_value;
		logic [3:0] digest_position;
		logic       checksum_present;
		logic       closing_delimiter_seen;
		logic       error_code;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} push_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} queue_status_t;

endpackage

// ----- rtl/zero_width_stego_text_decoder.sv -----
// Top level of the zero-width steganography text decoder.
// Instantiates zwsd_front and zwsd_queue; depends on zwsd_pkg.

// The block accepts one UTF-8 text byte per cycle on the slave side, with tlast
// marking the end of the text, and gives at most one result per transaction on
// the master side. Each result is registered into a two-entry result queue when
// its byte is accepted, and is shown once earlier ones are taken. The block keeps
// taking a byte every cycle as long as that queue is not full, so a steady
// one-byte-per-cycle stream passes when the consumer keeps tready high.
module zero_width_stego_text_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] text_byte
	input  logic        s_tlast,  // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] byte_value, [11:8] digest_position,
	                              // [12] checksum_present,
	                              // [13] closing_delimiter_seen, [14] error_code
	output logic [1:0]  m_tuser   // [1:0] result_kind
);
	import zwsd_pkg::*;

	push_t         push;
	result_t       head;
	queue_status_t qstat;
	logic          in_accept;

	assign s_tready  = !qstat.full;
	assign in_accept = s_tvalid && s_tready;
	assign m_tvalid  = !qstat.empty;

	zwsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.text_byte  (s_tdata),
		.end_of_text(s_tlast),
		.push       (push)
	);

	zwsd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (m_tvalid && m_tready),
		.head  (head),
		.status(qstat)
	);

	assign m_tuser = head.kind;
	assign m_tdata = {1'b0, head.error_code, head.closing_delimiter_seen,
		head.checksum_present, head.digest_position, head.byte_value};

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue count beyond its depth");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_ERROR) |-> (m_tdata[13:0] == 14'd0))
		else $error("error result carries nonzero data fields");

	a_position_digest_only: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != KIND_DIGEST) |-> (m_tdata[11:8] == 4'd0))
		else $error("digest position set on a result that is not a digest byte");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |=> m_tvalid)
		else $error("accepted result did not reach the output side");
`endif

endmodule

// ----- rtl/zwsd_front.sv -----
// Front part: accepts text bytes, hunts for the marker and decodes characters.
// Produces at most one result per transaction. Depends on zwsd_pkg.
module zwsd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     text_byte,
	input  logic           end_of_text,
	output zwsd_pkg::push_t push
);
	import zwsd_pkg::*;

	mode_t             mode_q, mode_d;
	logic [3:0]        read_q, read_d;
	logic [2:0]        match_q, match_d;
	logic [2:0]        len_q, len_d;
	logic [2:0]        fill_q, fill_d;
	logic [7:0]        cb0_q, cb0_d;
	logic [7:0]        cb1_q, cb1_d;
	logic [7:0]        asm_q, asm_d;
	logic [1:0]        slot_q, slot_d;
	logic [1:0]        delim_q, delim_d;
	logic [DCNT_W-1:0] dcnt_q, dcnt_d;
	logic              dnz_q, dnz_d;

	logic [2:0]        m;
	logic              full_match;
	logic              new_lead;
	logic [2:0]        lead_len;
	logic [2:0]        eff_fill;
	logic [2:0]        eff_len;
	logic              sym_hit;
	logic [1:0]        sym;
	logic [7:0]        asm_new;
	logic [DCNT_W+3:0] dcnt_ext;

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		unique casez (b)
			8'b0???????: len = 3'd1;
			8'b10??????: len = 3'd0;
			8'b110?????: len = 3'd2;
			8'b1110????: len = 3'd3;
			8'b11110???: len = 3'd4;
			8'b11111???: len = 3'd0;
		endcase
		return len;
	endfunction

	assign new_lead = (fill_q >= len_q);
	assign lead_len = lead_length(text_byte);
	assign eff_fill = new_lead ? 3'd0 : fill_q;
	assign eff_len  = new_lead ? lead_len : len_q;
	assign dcnt_ext = {4'd0, dcnt_q};

	always_comb begin
		sym_hit = 1'b0;
		sym     = 2'd0;
		if (eff_len == 3'd3 && cb0_q == BYTE_E2) begin
			if (cb1_q == BYTE_80) begin
				if (text_byte == BYTE_8B) begin
					sym_hit = 1'b1;
					sym     = 2'd0;
				end else if (text_byte == BYTE_8C) begin
					sym_hit = 1'b1;
					sym     = 2'd1;
				end else if (text_byte == BYTE_8D) begin
					sym_hit = 1'b1;
					sym     = 2'd2;
				end
			end else if (cb1_q == BYTE_81 && text_byte == BYTE_A0) begin
				sym_hit = 1'b1;
				sym     = 2'd3;
			end
		end
	end

	assign asm_new = asm_q | ({6'd0, sym} << {slot_q, 1'b0});

	always_comb begin
		m          = match_q;
		full_match = 1'b0;
		priority if (text_byte == BYTE_E2 && match_q == 3'd0) begin
			m = 3'd1;
		end else if (text_byte == BYTE_80 && match_q == 3'd1) begin
			m = 3'd2;
		end else if (text_byte == BYTE_8B && match_q == 3'd2) begin
			m = 3'd3;
		end else if (text_byte == BYTE_CD && match_q == 3'd3) begin
			m = 3'd4;
		end else if (text_byte == BYTE_8F && match_q == 3'd4) begin
			full_match = 1'b1;
		end else if (match_q != 3'd0) begin
			m = (text_byte == BYTE_E2) ? 3'd1 : 3'd0;
		end else begin
			m = 3'd0;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		read_d  = read_q;
		match_d = match_q;
		len_d   = len_q;
		fill_d  = fill_q;
		cb0_d   = cb0_q;
		cb1_d   = cb1_q;
		asm_d   = asm_q;
		slot_d  = slot_q;
		delim_d = delim_q;
		dcnt_d  = dcnt_q;
		dnz_d   = dnz_q;
		push    = '0;
		if (accept) begin
			if (end_of_text) begin
				push.valid = 1'b1;
				if (mode_q == MODE_DECODE) begin
					push.res.kind                   = KIND_END;
					push.res.checksum_present       = dnz_q;
					push.res.closing_delimiter_seen = (delim_q == 2'd2);
				end else begin
					push.res.kind       = KIND_ERROR;
					push.res.error_code = (mode_q == MODE_ERR_LEAD) ? ERR_BAD_LEAD
						: ERR_NO_MARKER;
				end
				mode_d  = MODE_HUNT;
				read_d  = 4'd0;
				match_d = 3'd0;
				len_d   = 3'd0;
				fill_d  = 3'd0;
				asm_d   = 8'd0;
				slot_d  = 2'd3;
				delim_d = 2'd0;
				dcnt_d  = '0;
				dnz_d   = 1'b0;
			end else begin
				unique case (mode_q)
					MODE_HUNT: begin
						if (full_match) begin
							mode_d  = MODE_DECODE;
							match_d = 3'd0;
							len_d   = 3'd0;
							fill_d  = 3'd0;
						end else begin
							match_d = m;
							if ((read_q == 4'd4 && m == 3'd0) ||
								({1'b0, read_q} + 5'd1 >= 5'(MARKER_WINDOW))) begin
								mode_d              = MODE_ERR_MARKER;
								push.valid          = 1'b1;
								push.res.kind       = KIND_ERROR;
								push.res.error_code = ERR_NO_MARKER;
							end else begin
								read_d = read_q + 4'd1;
							end
						end
					end
					MODE_DECODE: begin
						if (new_lead && lead_len == 3'd0) begin
							mode_d              = MODE_ERR_LEAD;
							push.valid          = 1'b1;
							push.res.kind       = KIND_ERROR;
							push.res.error_code = ERR_BAD_LEAD;
						end else begin
							len_d  = eff_len;
							fill_d = eff_fill + 3'd1;
							if (eff_fill == 3'd0) begin
								cb0_d = text_byte;
							end
							if (eff_fill == 3'd1) begin
								cb1_d = text_byte;
							end
							if (eff_fill + 3'd1 == eff_len) begin
								if (sym_hit) begin
									if (slot_q != 2'd0) begin
										asm_d  = asm_new;
										slot_d = slot_q - 2'd1;
									end else begin
										asm_d               = 8'd0;
										slot_d              = 2'd3;
										push.valid          = 1'b1;
										push.res.byte_value = asm_new;
										if (delim_q != 2'd0 &&
											dcnt_q < DCNT_W'(DIGEST_BYTES)) begin
											push.res.kind            = KIND_DIGEST;
											push.res.digest_position = dcnt_ext[3:0];
											dcnt_d                   = dcnt_q + 1'b1;
											if (asm_new != 8'd0) begin
												dnz_d = 1'b1;
											end
										end else begin
											push.res.kind = KIND_PAYLOAD;
										end
									end
								end else if (eff_len == 3'd2 && cb0_q == BYTE_CD &&
									text_byte == BYTE_8F) begin
									if (delim_q != 2'd2) begin
										delim_d = delim_q + 2'd1;
									end
								end
							end
						end
					end
					MODE_ERR_MARKER, MODE_ERR_LEAD: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_HUNT;
			read_q  <= 4'd0;
			match_q <= 3'd0;
			len_q   <= 3'd0;
			fill_q  <= 3'd0;
			asm_q   <= 8'd0;
			slot_q  <= 2'd3;
			delim_q <= 2'd0;
			dcnt_q  <= '0;
			dnz_q   <= 1'b0;
		end else begin
			mode_q  <= mode_d;
			read_q  <= read_d;
			match_q <= match_d;
			len_q   <= len_d;
			fill_q  <= fill_d;
			asm_q   <= asm_d;
			slot_q  <= slot_d;
			delim_q <= delim_d;
			dcnt_q  <= dcnt_d;
			dnz_q   <= dnz_d;
		end
	end

	always_ff @(posedge clk) begin
		cb0_q <= cb0_d;
		cb1_q <= cb1_d;
	end

endmodule

// ----- rtl/zwsd_queue.sv -----
// Short result queue that parts the front decoder from the output side.
// Holds decoded results until they are taken. Depends on zwsd_pkg.
module zwsd_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  zwsd_pkg::push_t         push,
	input  logic                    pop,
	output zwsd_pkg::result_t       head,
	output zwsd_pkg::queue_status_t status
);
	import zwsd_pkg::*;

	result_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign status.count = count_q;
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push.valid && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.res;
		end
	end

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for zero_width_stego_text_decoder.
// Streams UTF-8 carrier text into the block, predicts every decoded result and
// compares it with the master side. Depends on zwsd_pkg and the block's RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import zwsd_pkg::*;

	localparam logic [1:0] SYM_ZWSP = 2'd0;
	localparam logic [1:0] SYM_ZWNJ = 2'd1;
	localparam logic [1:0] SYM_ZWJ  = 2'd2;
	localparam logic [1:0] SYM_WJ   = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int unsigned text_items_sent = 0;
	int unsigned mismatch_count = 0;

	result_t     expected_results[$];

	mode_t             text_mode;
	logic [3:0]        marker_seen_bytes;
	logic [2:0]        marker_progress;
	logic [2:0]        char_span;
	logic [2:0]        char_filled;
	logic [7:0]        char_buf[4];
	logic [7:0]        hidden_byte;
	logic [1:0]        symbol_slot;
	logic [1:0]        delimiters;
	logic [DCNT_W-1:0] digest_taken;
	logic              digest_has_nonzero;

	zero_width_stego_text_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic void reset_text_model();
		text_mode          = MODE_HUNT;
		marker_seen_bytes  = '0;
		marker_progress    = '0;
		char_span          = '0;
		char_filled        = '0;
		for (int i = 0; i < 4; i++)
			char_buf[i] = 8'h00;
		hidden_byte        = 8'h00;
		symbol_slot        = 2'd3;
		delimiters         = '0;
		digest_taken       = '0;
		digest_has_nonzero = 1'b0;
	endfunction

	function automatic logic [2:0] utf8_char_span(input logic [7:0] lead);
		int ones;
		ones = 0;
		while (ones < 8 && lead[7 - ones])
			ones++;
		if (ones == 0)
			return 3'd1;
		if (ones >= 2 && ones <= 4)
			return 3'(ones);
		return 3'd0;
	endfunction

	function automatic bit take_symbol(input logic [1:0] sym, output result_t res);
		res = '0;
		hidden_byte = hidden_byte | ({6'd0, sym} << (2 * symbol_slot));
		if (symbol_slot != 2'd0) begin
			symbol_slot--;
			return 1'b0;
		end
		res.byte_value = hidden_byte;
		hidden_byte = 8'h00;
		symbol_slot = 2'd3;
		if (delimiters > 0 && digest_taken < DIGEST_BYTES) begin
			res.kind = KIND_DIGEST;
			res.digest_position = digest_taken[3:0];
			digest_taken++;
			if (res.byte_value != 8'h00)
				digest_has_nonzero = 1'b1;
		end else begin
			res.kind = KIND_PAYLOAD;
		end
		return 1'b1;
	endfunction

	function automatic bit hunt_marker(input logic [7:0] b, output result_t res);
		logic [2:0] m;
		res = '0;
		m = marker_progress;
		if (b == BYTE_E2 && m == 3'd0) begin
			m = 3'd1;
		end else if (b == BYTE_80 && m == 3'd1) begin
			m = 3'd2;
		end else if (b == BYTE_8B && m == 3'd2) begin
			m = 3'd3;
		end else if (b == BYTE_CD && m == 3'd3) begin
			m = 3'd4;
		end else if (b == BYTE_8F && m == 3'd4) begin
			text_mode       = MODE_DECODE;
			marker_progress = '0;
			char_span       = '0;
			char_filled     = '0;
			return 1'b0;
		end else if (m > 3'd0) begin
			m = (b == BYTE_E2) ? 3'd1 : 3'd0;
		end
		marker_progress = m;
		if ((marker_seen_bytes == 4'd4 && m == 3'd0) ||
		    marker_seen_bytes + 1 >= MARKER_WINDOW) begin
			text_mode = MODE_ERR_MARKER;
			res.kind = KIND_ERROR;
			res.error_code = ERR_NO_MARKER;
			return 1'b1;
		end
		marker_seen_bytes++;
		return 1'b0;
	endfunction

	function automatic bit decode_char_byte(input logic [7:0] b, output result_t res);
		logic [2:0] len;
		res = '0;
		if (char_filled >= char_span) begin
			len = utf8_char_span(b);
			if (len == 3'd0) begin
				text_mode = MODE_ERR_LEAD;
				res.kind = KIND_ERROR;
				res.error_code = ERR_BAD_LEAD;
				return 1'b1;
			end
			char_span = len;
			char_filled = '0;
		end
		char_buf[char_filled[1:0]] = b;
		char_filled++;
		if (char_filled != char_span)
			return 1'b0;
		if (char_span == 3'd3 && char_buf[0] == BYTE_E2) begin
			if (char_buf[1] == BYTE_80) begin
				if (char_buf[2] == BYTE_8B) return take_symbol(SYM_ZWSP, res);
				if (char_buf[2] == BYTE_8C) return take_symbol(SYM_ZWNJ, res);
				if (char_buf[2] == BYTE_8D) return take_symbol(SYM_ZWJ, res);
			end else if (char_buf[1] == BYTE_81 && char_buf[2] == BYTE_A0) begin
				return take_symbol(SYM_WJ, res);
			end
		end else if (char_span == 3'd2 && char_buf[0] == BYTE_CD && char_buf[1] == BYTE_8F) begin
			if (delimiters < 2'd2)
				delimiters++;
		end
		return 1'b0;
	endfunction

	function automatic bit predict_text_item(input logic [7:0] text_byte,
	                                         input logic end_of_text,
	                                         output result_t res);
		res = '0;
		if (end_of_text) begin
			if (text_mode == MODE_DECODE) begin
				res.kind = KIND_END;
				res.checksum_present = digest_has_nonzero;
				res.closing_delimiter_seen = (delimiters >= 2'd2);
			end else begin
				res.kind = KIND_ERROR;
				res.error_code = (text_mode == MODE_ERR_LEAD) ? ERR_BAD_LEAD : ERR_NO_MARKER;
			end
			reset_text_model();
			return 1'b1;
		end
		case (text_mode)
			MODE_HUNT:   return hunt_marker(text_byte, res);
			MODE_DECODE: return decode_char_byte(text_byte, res);
			default:     return 1'b0;
		endcase
	endfunction

	function automatic void compare_field(input string name, input int unsigned want,
	                                      input int unsigned got);
		if (want != got) begin
			mismatch_count++;
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
		end
	endfunction

	task automatic check_result(input result_t got);
		result_t want;
		if (expected_results.size() == 0) begin
			mismatch_count++;
			$error("unexpected result: kind %0d, byte 0x%02h", got.kind, got.byte_value);
			return;
		end
		want = expected_results.pop_front();
		compare_field("result_kind", want.kind, got.kind);
		compare_field("byte_value", want.byte_value, got.byte_value);
		compare_field("digest_position", want.digest_position, got.digest_position);
		compare_field("checksum_present", want.checksum_present, got.checksum_present);
		compare_field("closing_delimiter_seen", want.closing_delimiter_seen,
		              got.closing_delimiter_seen);
		compare_field("error_code", want.error_code, got.error_code);
	endtask

	always @(posedge clk) begin : result_monitor
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind                   = kind_t'(m_tuser);
			got.byte_value             = m_tdata[7:0];
			got.digest_position        = m_tdata[11:8];
			got.checksum_present       = m_tdata[12];
			got.closing_delimiter_seen = m_tdata[13];
			got.error_code             = m_tdata[14];
			check_result(got);
		end
	end

	task automatic send_text(input logic [7:0] text_byte, input logic end_of_text);
		result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= text_byte;
		s_tlast  <= end_of_text;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		text_items_sent++;
		if (predict_text_item(text_byte, end_of_text, res))
			expected_results.push_back(res);
	endtask

	task automatic wait_for_results();
		int unsigned waited;
		s_tvalid <= 1'b0;
		waited = 0;
		while (expected_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic send_marker();
		send_text(BYTE_E2, 1'b0);
		send_text(BYTE_80, 1'b0);
		send_text(BYTE_8B, 1'b0);
		send_text(BYTE_CD, 1'b0);
		send_text(BYTE_8F, 1'b0);
	endtask

	task automatic send_delimiter();
		send_text(BYTE_CD, 1'b0);
		send_text(BYTE_8F, 1'b0);
	endtask

	task automatic send_symbol(input logic [1:0] sym);
		send_text(BYTE_E2, 1'b0);
		send_text((sym == SYM_WJ) ? BYTE_81 : BYTE_80, 1'b0);
		case (sym)
			SYM_ZWSP: send_text(BYTE_8B, 1'b0);
			SYM_ZWNJ: send_text(BYTE_8C, 1'b0);
			SYM_ZWJ:  send_text(BYTE_8D, 1'b0);
			default:  send_text(BYTE_A0, 1'b0);
		endcase
	endtask

	task automatic send_other_char();
		case ($urandom_range(3))
			0: send_text(8'($urandom_range(8'h7f, 8'h00)), 1'b0);
			1: begin
				send_text(8'($urandom_range(8'hdf, 8'hc0)), 1'b0);
				send_text(8'($urandom_range(255)), 1'b0);
			end
			2: begin
				send_text(8'($urandom_range(8'hef, 8'he0)), 1'b0);
				repeat (2) send_text(8'($urandom_range(255)), 1'b0);
			end
			default: begin
				send_text(8'($urandom_range(8'hf7, 8'hf0)), 1'b0);
				repeat (3) send_text(8'($urandom_range(255)), 1'b0);
			end
		endcase
	endtask

	task automatic send_hidden_byte(input logic [7:0] value);
		for (int i = 3; i >= 0; i--) begin
			if ($urandom_range(11) == 0)
				send_other_char();
			send_symbol(value[2 * i +: 2]);
		end
	endtask

	task automatic test_symbols_and_delimiter();
		send_marker();
		send_symbol(SYM_ZWSP);
		send_symbol(SYM_ZWNJ);
		send_symbol(SYM_ZWJ);
		send_symbol(SYM_WJ);
		send_delimiter();
		send_text(8'hff, 1'b1);
	endtask

	task automatic test_marker_errors();
		send_text(8'h41, 1'b0);
		send_text(8'h42, 1'b0);
		send_text(8'h43, 1'b0);
		send_text(8'h44, 1'b0);
		send_text(8'h45, 1'b0);
		send_text(8'h00, 1'b0);
		send_text(8'h00, 1'b1);
		send_text(8'h5a, 1'b1);
	endtask

	task automatic test_restart_and_bad_lead();
		send_text(BYTE_E2, 1'b0);
		send_marker();
		send_text(8'hf8, 1'b0);
		send_text(8'h3c, 1'b1);
	endtask

	task automatic test_encoded_frames(input int unsigned budget);
		int unsigned start;
		int          digest_len;
		bit          zero_digest;
		start = text_items_sent;
		while (text_items_sent - start < budget) begin
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(4, 1)) send_text(8'($urandom_range(255)), 1'b0);
			send_marker();
			repeat ($urandom_range(3)) send_hidden_byte(8'($urandom_range(255)));
			if ($urandom_range(9) != 0) begin
				send_delimiter();
				digest_len = ($urandom_range(4) == 0) ? $urandom_range(18, 15) : $urandom_range(3);
				zero_digest = ($urandom_range(2) == 0);
				repeat (digest_len)
					send_hidden_byte(zero_digest ? 8'h00 : 8'($urandom_range(255)));
				if ($urandom_range(1)) begin
					send_delimiter();
					if ($urandom_range(3) == 0)
						send_delimiter();
					repeat ($urandom_range(2)) send_hidden_byte(8'($urandom_range(255)));
				end
			end
			if ($urandom_range(3) == 0)
				send_other_char();
			send_text(8'($urandom_range(255)), 1'b1);
		end
	endtask

	task automatic test_broken_frames(input int unsigned budget);
		int unsigned start;
		start = text_items_sent;
		while (text_items_sent - start < budget) begin
			if ($urandom_range(1)) begin
				repeat ($urandom_range(2)) send_text(8'($urandom_range(255)), 1'b0);
				send_marker();
			end else begin
				repeat ($urandom_range(7, 1)) begin
					case ($urandom_range(5))
						0: send_text(BYTE_E2, 1'b0);
						1: send_text(BYTE_80, 1'b0);
						2: send_text(BYTE_8B, 1'b0);
						3: send_text(BYTE_CD, 1'b0);
						4: send_text(BYTE_8F, 1'b0);
						default: send_text(8'($urandom_range(255)), 1'b0);
					endcase
				end
			end
			repeat ($urandom_range(12, 2)) begin
				case ($urandom_range(6))
					0: send_symbol(2'($urandom_range(3)));
					1: send_other_char();
					2: send_text($urandom_range(1) ? 8'($urandom_range(8'hbf, 8'h80)) :
					             8'($urandom_range(8'hff, 8'hf8)), 1'b0);
					3: begin
						send_text(BYTE_E2, 1'b0);
						send_text(BYTE_80, 1'b0);
					end
					4: send_delimiter();
					5: send_hidden_byte(8'($urandom_range(255)));
					default: begin
						case ($urandom_range(3))
							0: begin
								send_text(BYTE_E2, 1'b0);
								send_text(BYTE_80, 1'b0);
								send_text($urandom_range(1) ? 8'h8a : 8'h8e, 1'b0);
							end
							1: begin
								send_text(BYTE_E2, 1'b0);
								send_text(BYTE_81, 1'b0);
								send_text(8'ha1, 1'b0);
							end
							2: begin
								send_text(BYTE_CD, 1'b0);
								send_text(8'h8e, 1'b0);
							end
							default: begin
								send_text(BYTE_E2, 1'b0);
								send_text(BYTE_8B, 1'b0);
								send_text(BYTE_80, 1'b0);
							end
						endcase
					end
				endcase
			end
			send_text(8'($urandom_range(255)), 1'b1);
		end
	endtask

	task automatic test_byte_noise(input int unsigned budget);
		int unsigned start;
		start = text_items_sent;
		while (text_items_sent - start < budget)
			send_text(8'($urandom_range(255)), $urandom_range(29) == 0);
		send_text(8'($urandom_range(255)), 1'b1);
	endtask

	initial begin
		reset_text_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_symbols_and_delimiter();
		test_marker_errors();
		test_restart_and_bad_lead();
		wait_for_results();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 71;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 71;
				end
				default: begin
					send_idle_pct = 24;
					recv_stall_pct = 24;
				end
			endcase
			test_encoded_frames(240);
			test_broken_frames(70);
			test_byte_noise(40);
			wait_for_results();
		end
		if (expected_results.size() != 0) begin
			mismatch_count++;
			$error("%0d expected results never arrived", expected_results.size());
		end
		if (mismatch_count == 0) begin
			$display("zero_width_stego_text_decoder verification clean");
		end else begin
			$display("zero_width_stego_text_decoder verification failed");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("zero_width_stego_text_decoder verification failed");
		$finish;
	end

endmodule

// ----- zero_width_stego_text_decoder.f -----
rtl/zwsd_pkg.sv
rtl/zwsd_front.sv
rtl/zwsd_queue.sv
rtl/zero_width_stego_text_decoder.sv
sim/testbench.sv
